/* hdl/rrts_pkg.sv */
// Package for the round-robin task scheduler: word types, opcodes, stack states.
// No dependencies.
`default_nettype none
package rrts_pkg;
  localparam int MaxTasks  = 32;
  localparam int MaxStacks = 4;
  localparam int EventBits = 32;

  localparam logic [3:0] OP_ADD      = 4'd0;
  localparam logic [3:0] OP_DELETE   = 4'd1;
  localparam logic [3:0] OP_QUEUE    = 4'd2;
  localparam logic [3:0] OP_WAIT     = 4'd3;
  localparam logic [3:0] OP_FINISH   = 4'd4;
  localparam logic [3:0] OP_KILL     = 4'd5;
  localparam logic [3:0] OP_SET      = 4'd6;
  localparam logic [3:0] OP_CLEAR    = 4'd7;
  localparam logic [3:0] OP_SCHEDULE = 4'd8;

  localparam logic [1:0] ST_FREE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_RESUME = 2'd1;
  localparam logic [1:0] ACT_START  = 2'd2;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [4:0]  task_id;
    logic [31:0] event_mask;
  } cmd_t;

  typedef struct packed {
    logic       ok;
    logic [1:0] action;
    logic [1:0] stack_index;
    logic [4:0] task_out;
  } rsp_t;
endpackage
`default_nettype wire

/* hdl/round_robin_task_scheduler.sv */
// Round-robin task scheduler top level: sequencer and one shared scan step.
// Depends on rrts_pkg.
`default_nettype none
// A command word is taken when start is high and busy is low; exactly one result
// word follows on rsp, marked by done for a single cycle, and cannot be stalled.
// Set/clear flags, queue, wait and finish go from accept straight to S_DONE.
// Add, delete, kill and schedule walk ids or stacks one per cycle through a single
// compare step: add and kill stop at the first hit, delete walks every id, schedule
// scans the stacks, then ids up to highest_id. The scan loop sets the rate.
module round_robin_task_scheduler import rrts_pkg::*; #(
  parameter int MAX_TASKS  = MaxTasks,
  parameter int MAX_STACKS = MaxStacks,
  parameter int EVENT_BITS = EventBits
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t cmd,
  output logic      busy,
  output logic      done,
  output rsp_t      rsp
);
  localparam int TW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int SW = (MAX_STACKS > 1) ? $clog2(MAX_STACKS) : 1;
  localparam int CW = ((TW > SW) ? TW : SW) + 1;

  localparam logic [2:0] S_IDLE = 3'd0, S_ADD = 3'd1, S_DEL = 3'd2, S_KILL = 3'd3,
                         S_SSTK = 3'd4, S_STSK = 3'd5, S_DONE = 3'd6;

  logic [2:0] state;
  logic [MAX_TASKS-1:0] used_ids, queued_ids, active_ids;
  logic [1:0] stack_status [MAX_STACKS];
  logic [TW-1:0] stack_task [MAX_STACKS];
  logic [EVENT_BITS-1:0] stack_wait_mask [MAX_STACKS];
  logic [EVENT_BITS-1:0] event_flags;
  logic [TW-1:0] highest_id, last_task, tid;
  logic [SW-1:0] last_stack, running_stack, sidx, free_ix;
  logic have_free;
  logic [CW-1:0] cnt;
  cmd_t cmd_r;
  rsp_t res;

  logic [EVENT_BITS-1:0] msk;
  logic [4:0] id_in;
  logic run_ok;
  assign msk = cmd.event_mask[EVENT_BITS-1:0];
  assign id_in = cmd_r.task_id;
  assign run_ok = (stack_status[running_stack] == ST_RUN);
  assign busy = (state != S_IDLE);

  // next round-robin positions
  logic [SW-1:0] s_nx;
  logic [TW-1:0] t_nx;
  assign s_nx = (sidx == SW'(MAX_STACKS-1)) ? '0 : sidx + 1'b1;
  assign t_nx = (tid >= highest_id) ? '0 : tid + 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      used_ids <= '0; queued_ids <= '0; active_ids <= '0;
      event_flags <= '0; highest_id <= '0; last_stack <= '0;
      last_task <= '0; running_stack <= '0;
      for (int i = 0; i < MAX_STACKS; i++) begin
        stack_status[i] <= ST_FREE;
        stack_task[i] <= '0;
        stack_wait_mask[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r <= cmd;
            res <= '0;
            cnt <= '0;
            tid <= '0;
            state <= S_DONE;
            case (cmd.opcode)
              OP_ADD: begin tid <= '0; state <= S_ADD; end
              OP_DELETE: begin
                if ({27'd0, cmd.task_id} < 32'(MAX_TASKS)) begin
                  used_ids[cmd.task_id[TW-1:0]] <= 1'b0;
                  highest_id <= '0;
                  res.ok <= 1'b1;
                  state <= S_DEL;
                end
              end
              OP_QUEUE: begin
                if ({27'd0, cmd.task_id} < 32'(MAX_TASKS) &&
                    used_ids[cmd.task_id[TW-1:0]]) begin
                  queued_ids[cmd.task_id[TW-1:0]] <= 1'b1;
                  res.ok <= 1'b1;
                end
              end
              OP_WAIT: begin
                if (run_ok) begin
                  stack_status[running_stack] <= ST_WAIT;
                  stack_wait_mask[running_stack] <= msk;
                  res.ok <= 1'b1;
                end
              end
              OP_FINISH: begin
                if (run_ok) begin
                  active_ids[stack_task[running_stack]] <= 1'b0;
                  stack_status[running_stack] <= ST_FREE;
                  stack_task[running_stack] <= '0;
                  stack_wait_mask[running_stack] <= '0;
                  res.ok <= 1'b1;
                end
              end
              OP_KILL: begin sidx <= '0; state <= S_KILL; end
              OP_SET: begin event_flags <= event_flags | msk; res.ok <= 1'b1; end
              OP_CLEAR: begin event_flags <= event_flags & ~msk; res.ok <= 1'b1; end
              OP_SCHEDULE: begin
                sidx <= (last_stack == SW'(MAX_STACKS-1)) ? '0 : last_stack + 1'b1;
                have_free <= 1'b0;
                state <= S_SSTK;
              end
              default: ;
            endcase
          end
        end
        S_ADD: begin
          if (!used_ids[tid]) begin
            used_ids[tid] <= 1'b1;
            queued_ids[tid] <= 1'b0;
            if (highest_id < tid) highest_id <= tid;
            res.ok <= 1'b1;
            res.task_out <= 5'(tid);
            state <= S_DONE;
          end else if (tid == TW'(MAX_TASKS-1)) begin
            state <= S_DONE;
          end
          tid <= tid + 1'b1;
        end
        S_DEL: begin
          if (used_ids[tid]) highest_id <= tid;
          if (tid == TW'(MAX_TASKS-1)) state <= S_DONE;
          tid <= tid + 1'b1;
        end
        S_KILL: begin
          if (stack_status[sidx] != ST_FREE &&
              {{(32-TW){1'b0}}, stack_task[sidx]} == {27'd0, id_in}) begin
            active_ids[stack_task[sidx]] <= 1'b0;
            stack_status[sidx] <= ST_FREE;
            stack_task[sidx] <= '0;
            stack_wait_mask[sidx] <= '0;
            res.ok <= 1'b1;
            state <= S_DONE;
          end else if (sidx == SW'(MAX_STACKS-1)) begin
            state <= S_DONE;
          end
          sidx <= sidx + 1'b1;
        end
        S_SSTK: begin
          if (stack_status[sidx] == ST_FREE) begin
            have_free <= 1'b1;
            free_ix <= sidx;
          end
          if (stack_status[sidx] == ST_WAIT &&
              (stack_wait_mask[sidx] & event_flags) != '0) begin
            stack_status[sidx] <= ST_RUN;
            stack_wait_mask[sidx] <= '0;
            last_stack <= sidx;
            running_stack <= sidx;
            res.ok <= 1'b1;
            res.action <= ACT_RESUME;
            res.stack_index <= 2'(sidx);
            res.task_out <= 5'(stack_task[sidx]);
            state <= S_DONE;
          end else if (cnt == CW'(MAX_STACKS-1)) begin
            cnt <= '0;
            tid <= (last_task >= highest_id) ? '0 : last_task + 1'b1;
            state <= (have_free || stack_status[sidx] == ST_FREE) ? S_STSK : S_DONE;
          end else begin
            cnt <= cnt + 1'b1;
          end
          sidx <= s_nx;
        end
        S_STSK: begin
          if (used_ids[tid] && queued_ids[tid] && !active_ids[tid]) begin
            last_task <= tid;
            stack_status[free_ix] <= ST_RUN;
            stack_task[free_ix] <= tid;
            stack_wait_mask[free_ix] <= '0;
            active_ids[tid] <= 1'b1;
            queued_ids[tid] <= 1'b0;
            running_stack <= free_ix;
            res.ok <= 1'b1;
            res.action <= ACT_START;
            res.stack_index <= 2'(free_ix);
            res.task_out <= 5'(tid);
            state <= S_DONE;
          end else if (cnt[TW-1:0] == highest_id) begin
            state <= S_DONE;
          end
          cnt <= cnt + 1'b1;
          tid <= t_nx;
        end
        S_DONE: begin
          done <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign rsp = res;

  // a result word only ever follows a busy period
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("done without command");
  a_idle_after_done: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("busy during result");
  a_action_ok: assert property (@(posedge clk) disable iff (rst)
    done && rsp.action != ACT_NONE |-> rsp.ok) else $error("action without ok");
endmodule
`default_nettype wire

/* bench/tb.sv */
// Regression bench for round_robin_task_scheduler: directed and random command words
// checked against a behavioural scheduler model. Depends on rrts_pkg and the RTL.
`timescale 1ns / 1ps
module tb;
  import rrts_pkg::*;

  logic clk;
  logic rst;
  logic start;
  cmd_t cmd;
  logic busy;
  logic done;
  rsp_t rsp;

  round_robin_task_scheduler u_top (
    .clk(clk), .rst(rst), .start(start), .cmd(cmd),
    .busy(busy), .done(done), .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // scheduler model state
  logic [31:0] used_q, queued_q, active_q;
  logic [1:0]  stk_state [MaxStacks];
  logic [4:0]  stk_owner [MaxStacks];
  logic [31:0] stk_mask  [MaxStacks];
  logic [31:0] flags_q;
  logic [4:0]  top_id, prev_task;
  logic [1:0]  prev_stack, cur_stack;

  rsp_t  pending_rsp[$];
  int    mismatches;
  int    cycles;
  int    sender_idle;   // percent chance of a gap before a word

  task automatic model_reset();
    used_q = '0; queued_q = '0; active_q = '0;
    flags_q = '0; top_id = '0; prev_task = '0; prev_stack = '0; cur_stack = '0;
    for (int s = 0; s < MaxStacks; s++) begin
      stk_state[s] = ST_FREE; stk_owner[s] = '0; stk_mask[s] = '0;
    end
  endtask

  task automatic release_stack(input int s);
    active_q[stk_owner[s]] = 1'b0;
    stk_state[s] = ST_FREE; stk_owner[s] = '0; stk_mask[s] = '0;
  endtask

  // works out the reply word and advances the model
  task automatic schedule_predict(input cmd_t c, output rsp_t r);
    bit running, have_free, hit;
    int free_ix, s, t;
    running = (stk_state[cur_stack] == ST_RUN);
    r = '0;
    hit = 1'b0;
    case (c.opcode)
      OP_ADD: begin
        for (int i = 0; i < MaxTasks && !hit; i++) if (!used_q[i]) begin
          used_q[i] = 1'b1; queued_q[i] = 1'b0;
          if (top_id < i) top_id = i[4:0];
          r.ok = 1'b1; r.task_out = i[4:0]; hit = 1'b1;
        end
      end
      OP_DELETE: begin
        used_q[c.task_id] = 1'b0;
        top_id = '0;
        for (int i = 0; i < MaxTasks; i++) if (used_q[i]) top_id = i[4:0];
        r.ok = 1'b1;
      end
      OP_QUEUE: if (used_q[c.task_id]) begin
        queued_q[c.task_id] = 1'b1; r.ok = 1'b1;
      end
      OP_WAIT: if (running) begin
        stk_state[cur_stack] = ST_WAIT; stk_mask[cur_stack] = c.event_mask; r.ok = 1'b1;
      end
      OP_FINISH: if (running) begin
        release_stack(cur_stack); r.ok = 1'b1;
      end
      OP_KILL: begin
        for (s = 0; s < MaxStacks && !hit; s++)
          if (stk_state[s] != ST_FREE && stk_owner[s] == c.task_id) begin
            release_stack(s); r.ok = 1'b1; hit = 1'b1;
          end
      end
      OP_SET: begin flags_q |= c.event_mask; r.ok = 1'b1; end
      OP_CLEAR: begin flags_q &= ~c.event_mask; r.ok = 1'b1; end
      OP_SCHEDULE: begin
        have_free = 1'b0; free_ix = 0; s = prev_stack;
        // stacks first: resume a waiter whose mask meets the flags
        for (int i = 0; i < MaxStacks && r.action == ACT_NONE; i++) begin
          s = (s >= MaxStacks - 1) ? 0 : s + 1;
          if (stk_state[s] == ST_FREE) begin
            have_free = 1'b1; free_ix = s;
          end else if (stk_state[s] == ST_WAIT && (stk_mask[s] & flags_q) != 0) begin
            stk_state[s] = ST_RUN; stk_mask[s] = '0;
            prev_stack = s[1:0]; cur_stack = s[1:0];
            r.action = ACT_RESUME; r.stack_index = s[1:0]; r.task_out = stk_owner[s];
          end
        end
        // then ids round-robin up to the highest used one
        if (r.action == ACT_NONE && have_free) begin
          t = prev_task;
          for (int i = 0; i <= top_id && !hit; i++) begin
            t = (t >= top_id) ? 0 : t + 1;
            if (used_q[t] && queued_q[t] && !active_q[t]) begin
              prev_task = t[4:0];
              stk_state[free_ix] = ST_RUN; stk_owner[free_ix] = t[4:0];
              stk_mask[free_ix] = '0;
              active_q[t] = 1'b1; queued_q[t] = 1'b0;
              cur_stack = free_ix[1:0];
              r.action = ACT_START; r.stack_index = free_ix[1:0]; r.task_out = t[4:0];
              hit = 1'b1;
            end
          end
        end
        r.ok = (r.action != ACT_NONE);
      end
      default: ;
    endcase
  endtask

  task automatic send_word(input logic [3:0] op, input logic [4:0] id,
                           input logic [31:0] msk);
    cmd_t c;
    rsp_t r;
    c.opcode = op; c.task_id = id; c.event_mask = msk;
    while ($urandom_range(99) < sender_idle) @(posedge clk);
    start <= 1'b1;
    cmd   <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    // accepted at this edge
    schedule_predict(c, r);
    pending_rsp.push_back(r);
    start <= 1'b0;
    // the block is busy for at least the cycle after acceptance
    @(posedge clk);
  endtask

  // result checker: done words are sampled at the edge
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && done) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %p", rsp);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected ok=%0d act=%0d stk=%0d task=%0d, got %p",
                     want.ok, want.action, want.stack_index, want.task_out, rsp);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("round_robin_task_scheduler regression: fail");
      $finish;
    end
  end

  function automatic logic [3:0] pick_op();
    int p;
    p = $urandom_range(99);
    if (p < 14) return OP_ADD;
    if (p < 20) return OP_DELETE;
    if (p < 34) return OP_QUEUE;
    if (p < 44) return OP_WAIT;
    if (p < 52) return OP_FINISH;
    if (p < 58) return OP_KILL;
    if (p < 66) return OP_SET;
    if (p < 70) return OP_CLEAR;
    if (p < 97) return OP_SCHEDULE;
    return 4'($urandom_range(15, 9));
  endfunction

  function automatic logic [31:0] pick_mask();
    case ($urandom_range(3))
      0: return 32'h0;
      1: return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  task automatic test_directed();
    send_word(OP_SCHEDULE, 5'd0, 32'h0);          // idle when empty
    send_word(OP_WAIT, 5'd0, 32'h1);              // no running stack
    send_word(OP_FINISH, 5'd0, 32'h0);
    send_word(OP_QUEUE, 5'd31, 32'h0);            // unused id
    send_word(OP_KILL, 5'd31, 32'h0);
    for (int i = 0; i < 3; i++) send_word(OP_ADD, 5'd0, 32'h0);
    send_word(OP_QUEUE, 5'd1, 32'h0);
    send_word(OP_QUEUE, 5'd2, 32'h0);
    send_word(OP_SCHEDULE, 5'd0, 32'h0);
    send_word(OP_WAIT, 5'd0, 32'h8000_0000);
    send_word(OP_SCHEDULE, 5'd0, 32'h0);
    send_word(OP_SET, 5'd0, 32'hFFFF_FFFF);
    send_word(OP_SCHEDULE, 5'd0, 32'h0);          // resume the waiter
    send_word(OP_WAIT, 5'd0, 32'h0);              // zero mask: only kill frees it
    send_word(OP_KILL, 5'd1, 32'h0);
    send_word(OP_CLEAR, 5'd0, 32'hFFFF_FFFF);
    send_word(OP_DELETE, 5'd2, 32'h0);            // highest id recomputed
    send_word(OP_FINISH, 5'd0, 32'h0);
    send_word(4'd9, 5'd0, 32'h0);
    send_word(4'd15, 5'd31, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_table();
    for (int i = 0; i < 33; i++) send_word(OP_ADD, 5'd0, 32'h0);  // last three fail
    for (int i = 0; i < 8; i++) send_word(OP_QUEUE, 5'($urandom_range(31)), 32'h0);
    for (int i = 0; i < 6; i++) send_word(OP_SCHEDULE, 5'd0, 32'h0);
  endtask

  task automatic test_random(input int n, input int idle);
    sender_idle = idle;
    for (int i = 0; i < n; i++) begin
      logic [4:0] id;
      // ids mostly near the low end so queued ones are actually live
      id = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(7));
      send_word(pick_op(), id, pick_mask());
    end
  endtask

  initial begin
    clk = 1'b0; rst = 1'b1; start = 1'b0; cmd = '0;
    mismatches = 0; cycles = 0; sender_idle = 0;
    model_reset();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random(130, 0);
    test_random(130, 84);
    test_random(60, 18);
    test_random(60, 0);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0)
      $display("round_robin_task_scheduler regression: pass");
    else
      $display("round_robin_task_scheduler regression: fail");
    $finish;
  end
endmodule

/* filelist.f */
hdl/rrts_pkg.sv
hdl/round_robin_task_scheduler.sv
bench/tb.sv
